@@ rtl/rca_pkg.sv @@
// Shared widths, types and register indexes of the ray closest-approach pipeline.
package rca_pkg;

   localparam int WORD_W     = 32;
   localparam int NUM_FIELDS = 12;
   localparam int DIFF_W     = 33;
   localparam int PROD_W     = 64;
   localparam int CROSS_W    = 65;
   localparam int DET_W      = 100;
   localparam int QUOT_W     = 32;
   localparam int GAP_W      = 66;
   localparam int CSR_W      = 32;

   localparam logic CSR_PARALLEL_LIMIT = 1'b0;
   localparam logic CSR_HIT_TOLERANCE  = 1'b1;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic signed [DIFF_W-1:0] diff_type;
   typedef logic signed [DET_W-1:0]  det_type;

   typedef struct packed {
      word_type [2:0] d1;
      word_type [2:0] d2;
      diff_type [2:0] w;
      logic           par;
   } side_type;

endpackage

@@ rtl/rca_front.sv @@
// Cross product, rounding, squared norm, parallel test and both determinants.
module rca_front import rca_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [NUM_FIELDS*WORD_W-1:0] in_data,
   input  logic [WORD_W-1:0]            parallel_limit,
   output logic                         out_valid,
   input  logic                         out_ready,
   output det_type                      out_det1,
   output det_type                      out_det2,
   output logic [PROD_W-1:0]            out_n2,
   output side_type                     out_side
);

   localparam int NS = 7;
   localparam logic signed [CROSS_W:0] RND    = (CROSS_W+1)'(1) <<< (FRAC_BITS-1);
   localparam logic signed [CROSS_W:0] SAT_HI = (CROSS_W+1)'(64'sd2147483647);
   localparam logic signed [CROSS_W:0] SAT_LO = -(CROSS_W+1)'(64'sd2147483648);

   logic [NS-1:0] v_ff;
   logic          en;

   word_type o1 [3];
   word_type d1 [3];
   word_type o2 [3];
   word_type d2 [3];
   side_type side_in;

   logic signed [PROD_W-1:0]   prod_ff [6];
   word_type                   c_ff [3];
   word_type                   c_in [3];
   logic [PROD_W-1:0]          sq_ff [3];
   logic signed [PROD_W-1:0]   ep_ff [6];
   logic signed [PROD_W-1:0]   fp_ff [6];
   logic signed [CROSS_W-1:0]  e_ff [3];
   logic signed [CROSS_W-1:0]  f_ff [3];
   logic [PROD_W-1:0]          n2_ff [3:6];
   logic signed [2*DIFF_W-1:0] eh_ff [3];
   logic signed [2*DIFF_W-1:0] el_ff [3];
   logic signed [2*DIFF_W-1:0] fh_ff [3];
   logic signed [2*DIFF_W-1:0] fl_ff [3];
   det_type                    te_ff [3];
   det_type                    tf_ff [3];
   det_type                    det1_ff;
   det_type                    det2_ff;
   side_type                   side_ff [NS];
   side_type                   side_par_in;
   logic                       par_in;

   assign en       = out_ready || !v_ff[NS-1];
   assign in_ready = en;

   always_comb begin
      logic signed [CROSS_W:0] r;
      logic signed [CROSS_W:0] sh;
      for (int k = 0; k < 3; k++) begin
         o1[k] = in_data[WORD_W*k +: WORD_W];
         d1[k] = in_data[WORD_W*(3+k) +: WORD_W];
         o2[k] = in_data[WORD_W*(6+k) +: WORD_W];
         d2[k] = in_data[WORD_W*(9+k) +: WORD_W];
         side_in.d1[k] = d1[k];
         side_in.d2[k] = d2[k];
         side_in.w[k]  = DIFF_W'(o2[k]) - DIFF_W'(o1[k]);
      end
      side_in.par = 1'b0;
      for (int k = 0; k < 3; k++) begin
         r  = (CROSS_W+1)'(prod_ff[2*k]) - (CROSS_W+1)'(prod_ff[2*k+1]) + RND;
         sh = r >>> FRAC_BITS;
         if (sh > SAT_HI) begin
            c_in[k] = word_type'(SAT_HI[WORD_W-1:0]);
         end else if (sh < SAT_LO) begin
            c_in[k] = word_type'(SAT_LO[WORD_W-1:0]);
         end else begin
            c_in[k] = sh[WORD_W-1:0];
         end
      end
      par_in = n2_ff[3] <= (PROD_W'(parallel_limit) << FRAC_BITS);
      side_par_in     = side_ff[3];
      side_par_in.par = par_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[NS-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff[0] <= PROD_W'(d1[1]) * PROD_W'(d2[2]);
         prod_ff[1] <= PROD_W'(d1[2]) * PROD_W'(d2[1]);
         prod_ff[2] <= PROD_W'(d1[2]) * PROD_W'(d2[0]);
         prod_ff[3] <= PROD_W'(d1[0]) * PROD_W'(d2[2]);
         prod_ff[4] <= PROD_W'(d1[0]) * PROD_W'(d2[1]);
         prod_ff[5] <= PROD_W'(d1[1]) * PROD_W'(d2[0]);
         side_ff[0] <= side_in;
         for (int s = 1; s < NS; s++) begin
            if (s == 4) begin
               side_ff[s] <= side_par_in;
            end else begin
               side_ff[s] <= side_ff[s-1];
            end
         end

         for (int k = 0; k < 3; k++) begin
            c_ff[k] <= c_in[k];
         end

         for (int k = 0; k < 3; k++) begin
            sq_ff[k] <= $unsigned(PROD_W'(c_ff[k]) * PROD_W'(c_ff[k]));
         end
         ep_ff[0] <= PROD_W'($signed(side_ff[1].d2[1])) * PROD_W'(c_ff[2]);
         ep_ff[1] <= PROD_W'($signed(side_ff[1].d2[2])) * PROD_W'(c_ff[1]);
         ep_ff[2] <= PROD_W'($signed(side_ff[1].d2[2])) * PROD_W'(c_ff[0]);
         ep_ff[3] <= PROD_W'($signed(side_ff[1].d2[0])) * PROD_W'(c_ff[2]);
         ep_ff[4] <= PROD_W'($signed(side_ff[1].d2[0])) * PROD_W'(c_ff[1]);
         ep_ff[5] <= PROD_W'($signed(side_ff[1].d2[1])) * PROD_W'(c_ff[0]);
         fp_ff[0] <= PROD_W'($signed(side_ff[1].d1[1])) * PROD_W'(c_ff[2]);
         fp_ff[1] <= PROD_W'($signed(side_ff[1].d1[2])) * PROD_W'(c_ff[1]);
         fp_ff[2] <= PROD_W'($signed(side_ff[1].d1[2])) * PROD_W'(c_ff[0]);
         fp_ff[3] <= PROD_W'($signed(side_ff[1].d1[0])) * PROD_W'(c_ff[2]);
         fp_ff[4] <= PROD_W'($signed(side_ff[1].d1[0])) * PROD_W'(c_ff[1]);
         fp_ff[5] <= PROD_W'($signed(side_ff[1].d1[1])) * PROD_W'(c_ff[0]);

         n2_ff[3] <= sq_ff[0] + sq_ff[1] + sq_ff[2];
         for (int k = 0; k < 3; k++) begin
            e_ff[k] <= CROSS_W'(ep_ff[2*k]) - CROSS_W'(ep_ff[2*k+1]);
            f_ff[k] <= CROSS_W'(fp_ff[2*k]) - CROSS_W'(fp_ff[2*k+1]);
         end

         n2_ff[4] <= n2_ff[3];
         for (int k = 0; k < 3; k++) begin
            eh_ff[k] <= (2*DIFF_W)'($signed(side_ff[3].w[k]))
                      * (2*DIFF_W)'($signed(e_ff[k][CROSS_W-1:WORD_W]));
            el_ff[k] <= (2*DIFF_W)'($signed(side_ff[3].w[k]))
                      * (2*DIFF_W)'($signed({1'b0, e_ff[k][WORD_W-1:0]}));
            fh_ff[k] <= (2*DIFF_W)'($signed(side_ff[3].w[k]))
                      * (2*DIFF_W)'($signed(f_ff[k][CROSS_W-1:WORD_W]));
            fl_ff[k] <= (2*DIFF_W)'($signed(side_ff[3].w[k]))
                      * (2*DIFF_W)'($signed({1'b0, f_ff[k][WORD_W-1:0]}));
         end

         n2_ff[5] <= n2_ff[4];
         for (int k = 0; k < 3; k++) begin
            te_ff[k] <= (DET_W'(eh_ff[k]) <<< WORD_W) + DET_W'(el_ff[k]);
            tf_ff[k] <= (DET_W'(fh_ff[k]) <<< WORD_W) + DET_W'(fl_ff[k]);
         end

         n2_ff[6] <= n2_ff[5];
         det1_ff  <= te_ff[0] + te_ff[1] + te_ff[2];
         det2_ff  <= tf_ff[0] + tf_ff[1] + tf_ff[2];
      end
   end

   assign out_valid = v_ff[NS-1];
   assign out_det1  = det1_ff;
   assign out_det2  = det2_ff;
   assign out_n2    = n2_ff[6];
   assign out_side  = side_ff[NS-1];

endmodule

@@ rtl/rca_div.sv @@
// Pipelined restoring divider for both ray parameters, one quotient bit per stage.
module rca_div import rca_pkg::*; #(
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  det_type           in_num1,
   input  det_type           in_num2,
   input  logic [PROD_W-1:0] in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   input  logic              out_ready,
   output word_type          out_quot1,
   output word_type          out_quot2,
   output logic [SIDE_W-1:0] out_side
);

   localparam int NS = QUOT_W + 3;

   logic [NS-1:0] v_ff;
   logic          en;

   logic [DET_W-1:0]  rem_ff  [0:QUOT_W][2];
   logic [QUOT_W-1:0] q_ff    [2:QUOT_W+1][2];
   logic              neg_ff  [0:QUOT_W+1][2];
   logic              ovf_ff  [1:QUOT_W+1][2];
   logic [PROD_W-1:0] den_ff  [0:QUOT_W];
   logic [SIDE_W-1:0] side_ff [0:NS-1];
   word_type          quot_ff [2];
   det_type           num     [2];

   assign en       = out_ready || !v_ff[NS-1];
   assign in_ready = en;
   assign num[0]   = in_num1;
   assign num[1]   = in_num2;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[NS-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         den_ff[0]  <= in_den;
         side_ff[0] <= in_side;
         for (int s = 1; s < NS; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
         for (int s = 1; s <= QUOT_W; s++) begin
            den_ff[s] <= den_ff[s-1];
         end
         for (int n = 0; n < 2; n++) begin
            neg_ff[0][n] <= num[n][DET_W-1];
            rem_ff[0][n] <= num[n][DET_W-1] ? $unsigned(-num[n]) : $unsigned(num[n]);
            neg_ff[1][n] <= neg_ff[0][n];
            ovf_ff[1][n] <= rem_ff[0][n] >= (DET_W'(den_ff[0]) << QUOT_W);
            rem_ff[1][n] <= rem_ff[0][n];
            for (int s = 2; s <= QUOT_W + 1; s++) begin
               neg_ff[s][n] <= neg_ff[s-1][n];
               ovf_ff[s][n] <= ovf_ff[s-1][n];
            end
         end
      end
   end

   for (genvar j = 0; j < QUOT_W; j++) begin : g_step
      logic [DET_W-1:0]  sub;
      logic              take [2];
      logic [QUOT_W-1:0] prev [2];

      assign sub = DET_W'(den_ff[1+j]) << (QUOT_W-1-j);

      for (genvar n = 0; n < 2; n++) begin : g_lane
         assign take[n] = rem_ff[1+j][n] >= sub;
         if (j == 0) begin : g_first
            assign prev[n] = '0;
         end else begin : g_next
            assign prev[n] = q_ff[1+j][n];
         end

         always_ff @(posedge clock) begin
            if (en) begin
               q_ff[2+j][n] <= prev[n] | (QUOT_W'(take[n]) << (QUOT_W-1-j));
            end
         end

         if (j < QUOT_W - 1) begin : g_rem
            always_ff @(posedge clock) begin
               if (en) begin
                  rem_ff[2+j][n] <= take[n] ? rem_ff[1+j][n] - sub : rem_ff[1+j][n];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      logic [QUOT_W-1:0] q;
      if (en) begin
         for (int n = 0; n < 2; n++) begin
            q = q_ff[QUOT_W+1][n];
            if (neg_ff[QUOT_W+1][n]) begin
               if (ovf_ff[QUOT_W+1][n] || q > {1'b1, {(QUOT_W-1){1'b0}}}) begin
                  quot_ff[n] <= {1'b1, {(WORD_W-1){1'b0}}};
               end else begin
                  quot_ff[n] <= WORD_W'(-q);
               end
            end else begin
               if (ovf_ff[QUOT_W+1][n] || q[QUOT_W-1]) begin
                  quot_ff[n] <= {1'b0, {(WORD_W-1){1'b1}}};
               end else begin
                  quot_ff[n] <= WORD_W'(q);
               end
            end
         end
      end
   end

   assign out_valid = v_ff[NS-1];
   assign out_quot1 = quot_ff[0];
   assign out_quot2 = quot_ff[1];
   assign out_side  = side_ff[NS-1];

endmodule

@@ rtl/rca_hit.sv @@
// Closest points, per-axis gap test and the output register.
module rca_hit import rca_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  word_type          in_t1,
   input  word_type          in_t2,
   input  side_type          in_side,
   input  logic [WORD_W-2:0] hit_tolerance,
   output logic              out_valid,
   input  logic              out_ready,
   output word_type          out_t1,
   output word_type          out_t2,
   output logic              out_par,
   output logic              out_hit
);

   localparam int NS = 3;

   logic [NS-1:0] v_ff;
   logic          en;

   logic signed [GAP_W-1:0]  base_ff [3];
   logic signed [PROD_W-1:0] p1_ff [3];
   logic signed [PROD_W-1:0] p2_ff [3];
   logic signed [GAP_W-1:0]  g_ff [3];
   word_type                 t1_ff [2];
   word_type                 t2_ff [2];
   logic                     par_ff [2];
   word_type                 o_t1_ff;
   word_type                 o_t2_ff;
   logic                     o_par_ff;
   logic                     o_hit_ff;
   logic signed [GAP_W-1:0]  bound;
   logic                     hit_in;

   assign en       = out_ready || !v_ff[NS-1];
   assign in_ready = en;

   always_comb begin
      bound  = $signed(GAP_W'(hit_tolerance) << FRAC_BITS);
      hit_in = !par_ff[1];
      for (int k = 0; k < 3; k++) begin
         if (g_ff[k] > bound || g_ff[k] < -bound) begin
            hit_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[NS-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            base_ff[k] <= (-GAP_W'($signed(in_side.w[k]))) <<< FRAC_BITS;
            p1_ff[k]   <= PROD_W'(in_t1) * PROD_W'($signed(in_side.d1[k]));
            p2_ff[k]   <= PROD_W'(in_t2) * PROD_W'($signed(in_side.d2[k]));
         end
         t1_ff[0]  <= in_t1;
         t2_ff[0]  <= in_t2;
         par_ff[0] <= in_side.par;

         for (int k = 0; k < 3; k++) begin
            g_ff[k] <= base_ff[k] + GAP_W'(p1_ff[k]) - GAP_W'(p2_ff[k]);
         end
         t1_ff[1]  <= t1_ff[0];
         t2_ff[1]  <= t2_ff[0];
         par_ff[1] <= par_ff[0];

         o_t1_ff  <= par_ff[1] ? '0 : t1_ff[1];
         o_t2_ff  <= par_ff[1] ? '0 : t2_ff[1];
         o_par_ff <= par_ff[1];
         o_hit_ff <= hit_in;
      end
   end

   assign out_valid = v_ff[NS-1];
   assign out_t1    = o_t1_ff;
   assign out_t2    = o_t2_ff;
   assign out_par   = o_par_ff;
   assign out_hit   = o_hit_ff;

endmodule

@@ rtl/ray_closest_approach.sv @@
// Top level of the ray closest-approach pipeline.
// Takes one ray pair per cycle while the result side does not stall: seven stages form the
// cross product, its norm and the two determinants, 35 stages divide (a restoring divider
// with one quotient bit per stage sets this depth), and three stages test the closest
// points and hold the result. A stall on the result side holds the whole pipeline section
// behind a full last stage; nothing is dropped or repeated. The user must write registers
// through the csr_ port only while no transfer is in flight; the block does not enforce it.
module ray_closest_approach import rca_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // first_origin_x/y/z, first_dir_x/y/z, second_origin_x/y/z, second_dir_x/y/z
   input  logic [NUM_FIELDS*WORD_W-1:0] req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // first_param, second_param
   output logic [2*WORD_W-1:0]          rsp_tdata,
   // is_parallel, is_hit
   output logic [1:0]                   rsp_tuser,
   input  logic                         csr_wen,
   input  logic                         csr_addr,
   input  logic [CSR_W-1:0]             csr_wdata
);

   logic [WORD_W-1:0] limit_ff;
   logic [WORD_W-2:0] tol_ff;

   logic              f_valid, f_ready, d_valid, d_ready;
   det_type           f_det1, f_det2;
   logic [PROD_W-1:0] f_n2;
   side_type          f_side;
   word_type          d_t1, d_t2;
   logic [$bits(side_type)-1:0] d_side;
   word_type          h_t1, h_t2;
   logic              h_par, h_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= WORD_W'(1);
         tol_ff   <= (WORD_W-1)'(1);
      end else if (csr_wen) begin
         unique case (csr_addr)
            CSR_PARALLEL_LIMIT: limit_ff <= csr_wdata;
            CSR_HIT_TOLERANCE:  tol_ff   <= csr_wdata[WORD_W-2:0];
            default:            limit_ff <= limit_ff;
         endcase
      end
   end

   rca_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_tvalid),
      .in_ready       (req_tready),
      .in_data        (req_tdata),
      .parallel_limit (limit_ff),
      .out_valid      (f_valid),
      .out_ready      (f_ready),
      .out_det1       (f_det1),
      .out_det2       (f_det2),
      .out_n2         (f_n2),
      .out_side       (f_side)
   );

   rca_div #(.SIDE_W($bits(side_type))) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_num1   (f_det1),
      .in_num2   (f_det2),
      .in_den    (f_n2),
      .in_side   (f_side),
      .out_valid (d_valid),
      .out_ready (d_ready),
      .out_quot1 (d_t1),
      .out_quot2 (d_t2),
      .out_side  (d_side)
   );

   rca_hit #(.FRAC_BITS(FRAC_BITS)) u_hit (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (d_valid),
      .in_ready      (d_ready),
      .in_t1         (d_t1),
      .in_t2         (d_t2),
      .in_side       (side_type'(d_side)),
      .hit_tolerance (tol_ff),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_t1        (h_t1),
      .out_t2        (h_t2),
      .out_par       (h_par),
      .out_hit       (h_hit)
   );

   assign rsp_tdata = {h_t2, h_t1};
   assign rsp_tuser = {h_hit, h_par};

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the ray closest-approach pipeline with a built-in predictor.
`timescale 1ns / 100ps

module tb_top import rca_pkg::*; ();

   localparam int FRAC_BITS = 16;
   localparam int LATENCY   = 45;
   localparam int CYCLE_MAX = 400000;

   typedef logic signed [127:0] big_type;

   typedef struct packed {
      logic signed [31:0] first_param;
      logic signed [31:0] second_param;
      logic               is_parallel;
      logic               is_hit;
   } approach_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   // first_origin_x/y/z, first_dir_x/y/z, second_origin_x/y/z, second_dir_x/y/z
   logic [NUM_FIELDS*WORD_W-1:0] req_tdata = '0;
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   // first_param, second_param
   logic [2*WORD_W-1:0]          rsp_tdata;
   // is_parallel, is_hit
   logic [1:0]                   rsp_tuser;
   logic                         csr_wen = 1'b0;
   logic                         csr_addr = 1'b0;
   logic [CSR_W-1:0]             csr_wdata = '0;

   logic [31:0]  limit_reg = 32'd1;
   logic [30:0]  tol_reg   = 31'd1;
   approach_type approach_q[$];
   int           errors    = 0;
   int           cycles    = 0;
   int           send_idle = 0;
   int           rsp_stall = 0;

   ray_closest_approach #(.FRAC_BITS(FRAC_BITS)) dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_MAX) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   always @(posedge clock) rsp_tready <= ($urandom_range(99) >= rsp_stall);

   function automatic big_type sat32(big_type v);
      if (v > big_type'(32'sh7fffffff)) return big_type'(32'sh7fffffff);
      if (v < -big_type'(64'sh80000000)) return -big_type'(64'sh80000000);
      return v;
   endfunction

   function automatic big_type xc(big_type a1, big_type a2, big_type b1, big_type b2);
      return a1 * b2 - a2 * b1;
   endfunction

   function automatic approach_type predict_approach(logic [NUM_FIELDS*WORD_W-1:0] d);
      big_type o1[3], d1[3], o2[3], d2[3], c[3], e[3], f[3];
      big_type n2, det1, det2, t1, t2, g, tolb;
      approach_type r;
      int i, j;
      for (int k = 0; k < 3; k++) begin
         o1[k] = big_type'($signed(d[32*k +: 32]));
         d1[k] = big_type'($signed(d[32*(3+k) +: 32]));
         o2[k] = big_type'($signed(d[32*(6+k) +: 32]));
         d2[k] = big_type'($signed(d[32*(9+k) +: 32]));
      end
      n2 = '0;
      for (int k = 0; k < 3; k++) begin
         i = (k + 1) % 3;
         j = (k + 2) % 3;
         c[k] = sat32((xc(d1[i], d1[j], d2[i], d2[j]) + (big_type'(1) <<< (FRAC_BITS - 1)))
                      >>> FRAC_BITS);
         n2 += c[k] * c[k];
      end
      r = '0;
      if (n2 <= (big_type'(limit_reg) <<< FRAC_BITS)) begin
         r.is_parallel = 1'b1;
         return r;
      end
      det1 = '0;
      det2 = '0;
      for (int k = 0; k < 3; k++) begin
         i = (k + 1) % 3;
         j = (k + 2) % 3;
         e[k] = xc(d2[i], d2[j], c[i], c[j]);
         f[k] = xc(d1[i], d1[j], c[i], c[j]);
      end
      for (int k = 0; k < 3; k++) begin
         det1 += (o2[k] - o1[k]) * e[k];
         det2 += (o2[k] - o1[k]) * f[k];
      end
      t1 = sat32(det1 / n2);
      t2 = sat32(det2 / n2);
      tolb = big_type'(tol_reg) <<< FRAC_BITS;
      r.is_hit = 1'b1;
      for (int k = 0; k < 3; k++) begin
         g = ((o1[k] - o2[k]) <<< FRAC_BITS) + t1 * d1[k] - t2 * d2[k];
         if (g < 0) g = -g;
         if (g > tolb) r.is_hit = 1'b0;
      end
      r.first_param  = t1[31:0];
      r.second_param = t2[31:0];
      return r;
   endfunction

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         approach_q.push_back(predict_approach(req_tdata));
   end

   always @(posedge clock) begin
      approach_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (approach_q.size() == 0) begin
            $error("Result transfer with no expectation pending.");
            errors++;
         end else begin
            want = approach_q.pop_front();
            if (rsp_tdata[31:0] !== want.first_param) begin
               $error("first_param: expected %h, actual %h", want.first_param, rsp_tdata[31:0]);
               errors++;
            end
            if (rsp_tdata[63:32] !== want.second_param) begin
               $error("second_param: expected %h, actual %h", want.second_param,
                      rsp_tdata[63:32]);
               errors++;
            end
            if (rsp_tuser[0] !== want.is_parallel) begin
               $error("is_parallel: expected %b, actual %b", want.is_parallel, rsp_tuser[0]);
               errors++;
            end
            if (rsp_tuser[1] !== want.is_hit) begin
               $error("is_hit: expected %b, actual %b", want.is_hit, rsp_tuser[1]);
               errors++;
            end
         end
      end
   end

   task automatic send_pair(logic [NUM_FIELDS*WORD_W-1:0] d);
      if ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      while (approach_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic set_regs(logic [31:0] limit, logic [31:0] tol);
      csr_wen   <= 1'b1;
      csr_addr  <= CSR_PARALLEL_LIMIT;
      csr_wdata <= limit;
      @(posedge clock);
      csr_addr  <= CSR_HIT_TOLERANCE;
      csr_wdata <= tol;
      @(posedge clock);
      csr_wen   <= 1'b0;
      limit_reg = limit;
      tol_reg   = tol[30:0];
   endtask

   function automatic logic [NUM_FIELDS*WORD_W-1:0] pack_rays(
         logic [31:0] o1[3], logic [31:0] d1[3], logic [31:0] o2[3], logic [31:0] d2[3]);
      logic [NUM_FIELDS*WORD_W-1:0] d;
      for (int k = 0; k < 3; k++) begin
         d[32*k +: 32]     = o1[k];
         d[32*(3+k) +: 32] = d1[k];
         d[32*(6+k) +: 32] = o2[k];
         d[32*(9+k) +: 32] = d2[k];
      end
      return d;
   endfunction

   function automatic logic [31:0] srand(int bits);
      return $signed($urandom) >>> (32 - bits);
   endfunction

   function automatic logic [NUM_FIELDS*WORD_W-1:0] random_pair();
      logic [31:0] o1[3], d1[3], o2[3], d2[3];
      logic signed [63:0] p, t1, t2;
      int kind = $urandom_range(9);
      for (int k = 0; k < 3; k++) begin
         o1[k] = srand(22);
         o2[k] = srand(22);
         d1[k] = srand(18);
         d2[k] = srand(18);
      end
      case (kind)
         0, 1: begin
            for (int k = 0; k < 3; k++) begin
               o1[k] = $urandom; o2[k] = $urandom; d1[k] = $urandom; d2[k] = $urandom;
            end
         end
         2: begin
            for (int k = 0; k < 3; k++) d2[k] = ($urandom_range(1)) ? d1[k] : -d1[k];
         end
         3: begin
            for (int k = 0; k < 3; k++) d2[k] = d1[k] + srand(3);
         end
         default: begin
            t1 = 64'($signed(srand(20)));
            t2 = 64'($signed(srand(20)));
            for (int k = 0; k < 3; k++) begin
               p = 64'($signed(srand(22)));
               o1[k] = 32'(p - ((t1 * 64'($signed(d1[k]))) >>> FRAC_BITS));
               o2[k] = 32'(p - ((t2 * 64'($signed(d2[k]))) >>> FRAC_BITS));
            end
         end
      endcase
      return pack_rays(o1, d1, o2, d2);
   endfunction

   task automatic test_directed;
      logic [31:0] o1[3], d1[3], o2[3], d2[3];
      logic [31:0] one = 32'h0001_0000;
      logic [31:0] vals[6] = '{32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff, one, -one};
      for (int v = 0; v < 6; v++) begin
         for (int k = 0; k < 3; k++) begin
            o1[k] = vals[v]; d1[k] = vals[v]; o2[k] = vals[5-v]; d2[k] = vals[(v+2)%6];
         end
         send_pair(pack_rays(o1, d1, o2, d2));
      end
      // Unit rays along x and y meeting at a common point.
      o1 = '{0, 0, 0};       d1 = '{one, 0, 0};
      o2 = '{one, -one, 0};  d2 = '{0, one, 0};
      send_pair(pack_rays(o1, d1, o2, d2));
      // Skew rays: gap on the z axis only.
      o2 = '{one, -one, one};
      send_pair(pack_rays(o1, d1, o2, d2));
      // Identical directions.
      d2 = d1;
      send_pair(pack_rays(o1, d1, o2, d2));
      // Oversized directions drive the cross product into saturation.
      d1 = '{32'h7fffffff, 32'h80000000, 32'h7fffffff};
      d2 = '{32'h80000000, 32'h7fffffff, 32'h7fffffff};
      send_pair(pack_rays(o1, d1, o2, d2));
      // Nearly parallel rays with far origins overflow the parameters.
      d1 = '{one, 0, 0};
      d2 = '{one, 32'h0000_0200, 0};
      o1 = '{32'h80000000, 32'h80000000, 32'h80000000};
      o2 = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
      send_pair(pack_rays(o1, d1, o2, d2));
      o1 = o2;
      o2 = '{32'h80000000, 32'h80000000, 32'h80000000};
      send_pair(pack_rays(o1, d1, o2, d2));
      // Zero directions against a zero limit.
      drain();
      set_regs(32'h0, 32'h0);
      d1 = '{0, 0, 0};
      d2 = '{0, 0, 0};
      send_pair(pack_rays(o1, d1, o2, d2));
      d1 = '{one, 0, 0};
      d2 = '{0, one, 0};
      o1 = '{0, 0, 0};
      o2 = '{one, -one, 0};
      send_pair(pack_rays(o1, d1, o2, d2));
      drain();
   endtask

   task automatic test_random(logic [31:0] limit, logic [31:0] tol, int idle, int stall,
                              int count);
      set_regs(limit, tol);
      send_idle = idle;
      rsp_stall = stall;
      for (int n = 0; n < count; n++) send_pair(random_pair());
      drain();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(32'd1, 32'd1, 0, 0, 130);
      test_random(32'd0, 32'h0000_0400, 48, 0, 130);
      test_random(32'hffffffff, 32'hffffffff, 0, 48, 100);
      test_random(32'h0000_0100, 32'h0001_0000, 30, 30, 130);
      test_random($urandom, $urandom, 30, 30, 130);
      test_random(32'd5, 32'h7fffffff, 0, 0, 100);
      test_random(32'h0000_0010, 32'h0000_0040, 48, 48, 80);
      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

@@ files.f @@
rtl/rca_pkg.sv
rtl/rca_front.sv
rtl/rca_div.sv
rtl/rca_hit.sv
rtl/ray_closest_approach.sv
tb/tb_top.sv
